@@ rtl/lspp_pkg.sv @@
`timescale 1ns / 1ps

package lspp_pkg;

    // strip geometry and animation defaults
    localparam int NUM_LEDS_DEF    = 56;
    localparam int DROP_LENGTH_DEF = 8;

    // field widths
    localparam int MODE_W  = 2;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 6;
    localparam int LEVEL_W = 8;
    localparam int PHASE_W = 4;
    // white count holds 0..64, product holds part * 64
    localparam int CNT_W   = 7;
    localparam int PROD_W  = DATA_W + CNT_W;
    localparam int STEP_W  = 3;

    // color levels
    localparam logic [LEVEL_W-1:0] WHITE_LEVEL = 8'd90;
    localparam logic [LEVEL_W-1:0] ERROR_LEVEL = 8'd70;
    localparam logic [LEVEL_W-1:0] DROP_LVL_0  = 8'd255;
    localparam logic [LEVEL_W-1:0] DROP_LVL_1  = 8'd150;
    localparam logic [LEVEL_W-1:0] DROP_LVL_2  = 8'd75;
    localparam logic [LEVEL_W-1:0] DROP_LVL_3  = 8'd30;
    localparam logic [LEVEL_W-1:0] SOLID_LEVEL = 8'd255;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF   = 2'd0,
        MODE_SOLID = 2'd1,
        MODE_DROP  = 2'd2,
        MODE_ERROR = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_CHECK,
        F_DIV,
        F_PUSH
    } front_state_t;

    // one classified frame handed from front to back
    typedef struct packed {
        mode_t             mode;
        logic [CNT_W-1:0]  white;
        logic [DATA_W-1:0] pattern;
    } frame_job_t;

endpackage

@@ rtl/lspp_frame_if.sv @@
`timescale 1ns / 1ps

interface lspp_frame_if;
    import lspp_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] part;
    logic [DATA_W-1:0] full_req;

    modport source (output valid, output mode, output part, output full_req, input ready);
    modport sink   (input valid, input mode, input part, input full_req, output ready);
endinterface

@@ rtl/lspp_pixel_if.sv @@
`timescale 1ns / 1ps

interface lspp_pixel_if;
    import lspp_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   led_index;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] blue;
    logic               last_led;

    modport source (output valid, output led_index, output green, output red, output blue,
                    output last_led, input ready);
    modport sink   (input valid, input led_index, input green, input red, input blue,
                    input last_led, output ready);
endinterface

@@ rtl/lspp_front.sv @@
`timescale 1ns / 1ps

module lspp_front
    import lspp_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    lspp_frame_if.sink   frame,
    output logic         push_valid,
    input  logic         push_ready,
    output frame_job_t   push_job
);

    front_state_t      state_reg, state_next;
    mode_t             mode_reg;
    logic [DATA_W-1:0] full_reg;
    logic [DATA_W-1:0] part_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] div_reg;
    logic [CNT_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  white_reg;

    logic              rem_ge;
    logic              sat_hit;
    logic [CNT_W-1:0]  quo_step;

    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(NUM_LEDS);

    // one restoring division step and the saturation test
    assign rem_ge   = rem_reg >= div_reg;
    assign sat_hit  = rem_reg >= {full_reg, {CNT_W{1'b0}}};
    assign quo_step = {quo_reg[CNT_W-2:0], rem_ge};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (frame.valid) state_next = F_MUL;
            F_MUL:   state_next = F_CHECK;
            F_CHECK:
            begin
                if (full_reg == '0 || sat_hit)
                    state_next = F_PUSH;
                else
                    state_next = F_DIV;
            end
            F_DIV:   if (step_reg == '0) state_next = F_PUSH;
            F_PUSH:  if (push_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        frame.ready = 1'b0;
        push_valid  = 1'b0;
        unique case (state_reg)
            F_IDLE:  frame.ready = 1'b1;
            F_PUSH:  push_valid  = 1'b1;
            default: ;
        endcase
    end

    assign push_job.mode    = mode_reg;
    assign push_job.white   = white_reg;
    assign push_job.pattern = full_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath: multiply, saturate, then one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (frame.valid)
                begin
                    mode_reg <= mode_t'(frame.mode);
                    part_reg <= frame.part;
                    full_reg <= frame.full_req;
                end
            end
            F_MUL:
            begin
                rem_reg <= {{CNT_W{1'b0}}, part_reg} * PROD_W'(NUM_LEDS);
            end
            F_CHECK:
            begin
                div_reg  <= {1'b0, full_reg, {(CNT_W-1){1'b0}}};
                quo_reg  <= '0;
                step_reg <= STEP_W'(CNT_W - 1);
                if (full_reg == '0)
                    white_reg <= '0;
                else
                    white_reg <= N_CNT;
            end
            F_DIV:
            begin
                if (rem_ge)
                    rem_reg <= rem_reg - div_reg;
                div_reg  <= div_reg >> 1;
                quo_reg  <= quo_step;
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                    white_reg <= (quo_step > N_CNT) ? N_CNT : quo_step;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/lspp_queue.sv @@
`timescale 1ns / 1ps

module lspp_queue
    import lspp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  frame_job_t push_job,
    output logic       pop_valid,
    input  logic       pop_ready,
    output frame_job_t pop_job
);

    frame_job_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ rtl/lspp_back.sv @@
`timescale 1ns / 1ps

module lspp_back
    import lspp_pkg::*;
#(
    parameter int NUM_LEDS    = NUM_LEDS_DEF,
    parameter int DROP_LENGTH = DROP_LENGTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  frame_job_t   pop_job,
    lspp_pixel_if.source pixel
);

    localparam logic [PHASE_W-1:0] TOP      = PHASE_W'(DROP_LENGTH);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(NUM_LEDS - 1);

    function automatic logic [PHASE_W-1:0] phase_down(input logic [PHASE_W-1:0] p);
        if (p <= PHASE_W'(1) || p > TOP)
            return TOP;
        return p - 1'b1;
    endfunction

    function automatic logic [LEVEL_W-1:0] drop_level(input logic [PHASE_W-1:0] p);
        if (p == TOP)                return DROP_LVL_0;
        if (p == TOP - PHASE_W'(1))  return DROP_LVL_1;
        if (p == TOP - PHASE_W'(2))  return DROP_LVL_2;
        if (p == TOP - PHASE_W'(3))  return DROP_LVL_3;
        return '0;
    endfunction

    logic               busy_reg;
    mode_t              mode_reg;
    logic [CNT_W-1:0]   white_reg;
    logic [DATA_W-1:0]  pattern_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] drop_phase_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [LEVEL_W-1:0] out_green_reg;
    logic [LEVEL_W-1:0] out_red_reg;
    logic [LEVEL_W-1:0] out_blue_reg;
    logic               out_last_reg;

    logic               emit;
    logic               is_white;
    logic               is_last;
    logic [LEVEL_W-1:0] green_next;
    logic [LEVEL_W-1:0] red_next;
    logic [LEVEL_W-1:0] blue_next;

    assign pop_ready = !busy_reg;
    assign emit      = busy_reg && (!out_valid_reg || pixel.ready);
    assign is_white  = {1'b0, idx_reg} < white_reg;
    assign is_last   = idx_reg == LAST_IDX;

    // colors of the current led
    always_comb
    begin
        green_next = '0;
        red_next   = '0;
        blue_next  = '0;
        if (is_white)
        begin
            green_next = WHITE_LEVEL;
            red_next   = WHITE_LEVEL;
            blue_next  = WHITE_LEVEL;
        end
        else
        begin
            case (mode_reg)
                MODE_DROP:  blue_next = drop_level(phase_reg);
                MODE_SOLID: blue_next = SOLID_LEVEL;
                MODE_ERROR: if (pattern_reg[0]) red_next = ERROR_LEVEL;
                default:    ;
            endcase
        end
    end

    // frame walk and kept droplet phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            drop_phase_reg <= TOP;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!busy_reg && pop_valid)
                busy_reg <= 1'b1;
            else if (emit && is_last)
            begin
                busy_reg <= 1'b0;
                if (mode_reg == MODE_DROP)
                    drop_phase_reg <= phase_down(drop_phase_reg);
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (pixel.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // per-frame job data and output word
    always_ff @(posedge clk)
    begin
        if (!busy_reg && pop_valid)
        begin
            mode_reg    <= pop_job.mode;
            white_reg   <= pop_job.white;
            pattern_reg <= pop_job.pattern;
            phase_reg   <= drop_phase_reg;
            idx_reg     <= '0;
        end
        else if (emit)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (!is_white && mode_reg == MODE_DROP)
                phase_reg <= phase_down(phase_reg);
            if (mode_reg == MODE_ERROR)
                pattern_reg <= {1'b1, pattern_reg[DATA_W-1:1]};
        end

        if (emit)
        begin
            out_idx_reg   <= idx_reg;
            out_green_reg <= green_next;
            out_red_reg   <= red_next;
            out_blue_reg  <= blue_next;
            out_last_reg  <= is_last;
        end
    end

    assign pixel.valid     = out_valid_reg;
    assign pixel.led_index = out_idx_reg;
    assign pixel.green     = out_green_reg;
    assign pixel.red       = out_red_reg;
    assign pixel.blue      = out_blue_reg;
    assign pixel.last_led  = out_last_reg;

endmodule

@@ rtl/led_strip_progress_pattern_unit.sv @@
`timescale 1ns / 1ps

// channel  direction  word
// frame    in         mode, part, full_req (one request per frame)
// pixel    out        led_index, green, red, blue, last_led (one per led)
//
// the front takes a request, forms part * NUM_LEDS in its multiply state and
// finds the white count with a restoring divider, one quotient bit a cycle.
// a two-entry queue feeds the back, which sends one led word a cycle while
// the pixel channel is ready. reset clears the handshakes, empties the
// queue and sets the droplet phase to DROP_LENGTH. a stalled pixel channel
// holds the back, and the front as well once the queue is full.

module led_strip_progress_pattern_unit
    import lspp_pkg::*;
#(
    parameter int NUM_LEDS    = NUM_LEDS_DEF,
    parameter int DROP_LENGTH = DROP_LENGTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    lspp_frame_if.sink   frame,
    lspp_pixel_if.source pixel
);

    logic       push_valid;
    logic       push_ready;
    frame_job_t push_job;
    logic       pop_valid;
    logic       pop_ready;
    frame_job_t pop_job;

    // request classification and white count
    lspp_front #(
        .NUM_LEDS (NUM_LEDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // job queue between front and back
    lspp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // led pattern generation
    lspp_back #(
        .NUM_LEDS    (NUM_LEDS),
        .DROP_LENGTH (DROP_LENGTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .pixel     (pixel)
    );

endmodule

@@ tb/tb_led_strip_progress_pattern_unit.sv @@
`timescale 1ns / 1ps

import lspp_pkg::*;

typedef struct packed {
    logic [IDX_W-1:0]   led_index;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] blue;
    logic               last_led;
} led_word_t;

// renders each accepted frame request into the led words it must produce
class strip_frame_tracker;
    localparam int LED_COUNT = NUM_LEDS_DEF;
    localparam int DROP_LEN  = DROP_LENGTH_DEF;

    led_word_t         pending_leds[$];
    logic [PHASE_W-1:0] drop_phase;
    int                errors;

    function new();
        drop_phase = PHASE_W'(DROP_LEN);
        errors     = 0;
    endfunction

    // droplet phase counts down and wraps from 1 to the drop length
    function logic [PHASE_W-1:0] phase_step(logic [PHASE_W-1:0] p);
        if (p <= 1 || p > DROP_LEN)
            return PHASE_W'(DROP_LEN);
        return p - 1'b1;
    endfunction

    function int pending();
        return pending_leds.size();
    endfunction

    // accepted request: expand into one word per led
    function void note_frame(mode_t mode, logic [DATA_W-1:0] part, logic [DATA_W-1:0] full);
        logic [63:0]        lit;
        logic [DATA_W-1:0]  pattern;
        logic [PHASE_W-1:0] ph;
        led_word_t          w;
        lit = 64'd0;
        if (part != 0 && full != 0)
        begin
            lit = ({32'd0, part} * 64'(LED_COUNT)) / {32'd0, full};
            if (lit > LED_COUNT)
                lit = 64'(LED_COUNT);
        end
        pattern = full;
        ph      = drop_phase;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            w           = '0;
            w.led_index = IDX_W'(i);
            if (64'(i) < lit)
            begin
                w.green = WHITE_LEVEL;
                w.red   = WHITE_LEVEL;
                w.blue  = WHITE_LEVEL;
            end
            else
            begin
                case (mode)
                    MODE_DROP:
                    begin
                        if (ph == DROP_LEN)
                            w.blue = DROP_LVL_0;
                        else if (ph == DROP_LEN - 1)
                            w.blue = DROP_LVL_1;
                        else if (ph == DROP_LEN - 2)
                            w.blue = DROP_LVL_2;
                        else if (ph == DROP_LEN - 3)
                            w.blue = DROP_LVL_3;
                        ph = phase_step(ph);
                    end
                    MODE_SOLID: w.blue = SOLID_LEVEL;
                    MODE_ERROR:
                    begin
                        if (pattern[0])
                            w.red = ERROR_LEVEL;
                    end
                    default: ;
                endcase
            end
            // error pattern shifts on every led, white ones too
            if (mode == MODE_ERROR)
                pattern = {1'b1, pattern[DATA_W-1:1]};
            w.last_led = (i == LED_COUNT - 1);
            pending_leds.push_back(w);
        end
        if (mode == MODE_DROP)
            drop_phase = phase_step(drop_phase);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // accepted led word: compare with the oldest expectation
    function void check_led(led_word_t got);
        led_word_t want;
        if (pending_leds.size() == 0)
        begin
            $error("led word with no frame pending: led_index %0d", got.led_index);
            errors++;
            return;
        end
        want = pending_leds.pop_front();
        compare_field("led_index", want.led_index, got.led_index);
        compare_field("green", want.green, got.green);
        compare_field("red", want.red, got.red);
        compare_field("blue", want.blue, got.blue);
        compare_field("last_led", want.last_led, got.last_led);
    endfunction
endclass

module tb_led_strip_progress_pattern_unit;
    localparam int LED_COUNT     = NUM_LEDS_DEF;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_FRAMES = 280;

    logic clk;
    logic rst_n;
    bit   idle_en;
    int   quiet_cycles;

    strip_frame_tracker sb;

    lspp_frame_if frame_ch();
    lspp_pixel_if pixel_ch();

    led_strip_progress_pattern_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame_ch),
        .pixel (pixel_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // offer one frame request and hold it until accepted
    task automatic send_frame(mode_t mode, logic [DATA_W-1:0] part, logic [DATA_W-1:0] full);
        int gap;
        gap = idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.valid    <= 1'b1;
        frame_ch.mode     <= mode;
        frame_ch.part     <= part;
        frame_ch.full_req <= full;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
    endtask

    // hold off new requests until every led word has come back
    task automatic wait_strip_drained();
        frame_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // led word receiver with random back-pressure
    initial
    begin
        int stall;
        pixel_ch.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = idle_en ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                pixel_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pixel_ch.ready <= 1'b1;
            @(posedge clk);
            while (!pixel_ch.valid)
                @(posedge clk);
        end
    end

    // monitor both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_ch.valid && frame_ch.ready)
                sb.note_frame(mode_t'(frame_ch.mode), frame_ch.part, frame_ch.full_req);
            if (pixel_ch.valid && pixel_ch.ready)
                sb.check_led('{pixel_ch.led_index, pixel_ch.green, pixel_ch.red,
                               pixel_ch.blue, pixel_ch.last_led});
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (frame_ch.valid && frame_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("led_strip_progress_pattern_unit verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [DATA_W-1:0] part;
        logic [DATA_W-1:0] full;
        int                sel;
        sb                = new();
        idle_en           = 1'b1;
        rst_n             = 1'b0;
        frame_ch.valid    = 1'b0;
        frame_ch.mode     = MODE_OFF;
        frame_ch.part     = '0;
        frame_ch.full_req = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero progress in the off, solid and error modes, then the zero denominator
        send_frame(MODE_OFF, 32'd0, 32'h1234_5678);
        send_frame(MODE_SOLID, 32'd0, 32'hFFFF_FFFF);
        send_frame(MODE_ERROR, 32'd0, 32'hAAAA_AAAA);
        send_frame(MODE_ERROR, 32'hFFFF_FFFF, 32'd0);
        send_frame(MODE_SOLID, 32'd7, 32'd0);
        // full progress, saturation and wide products
        send_frame(MODE_OFF, 32'd100, 32'd100);
        send_frame(MODE_SOLID, 32'hFFFF_FFFF, 32'd1);
        send_frame(MODE_ERROR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_frame(MODE_SOLID, 32'h8000_0000, 32'hFFFF_FFFF);
        send_frame(MODE_OFF, 32'd1, 32'd56);
        send_frame(MODE_SOLID, 32'd55, 32'd56);
        send_frame(MODE_OFF, 32'd1, 32'hFFFF_FFFF);
        // error bits behind a white head, then a single one at the low and at the high end
        send_frame(MODE_ERROR, 32'd10, 32'd100);
        send_frame(MODE_ERROR, 32'd0, 32'h0000_0001);
        send_frame(MODE_ERROR, 32'd0, 32'h8000_0000);
        // droplet through a full phase wrap, with and without white leds
        for (int i = 0; i < 10; i++)
            send_frame(MODE_DROP, (i % 3 == 0) ? 32'd0 : 32'(i * 3), 32'd20);
        wait_strip_drained();

        // random requests in blocks, idling switched per block
        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            if (n % 25 == 0)
            begin
                idle_en = (n == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 2) == 0)
                    wait_strip_drained();
            end
            sel  = $urandom_range(0, 9);
            full = $urandom();
            part = $urandom();
            case (sel)
                0: full = 32'd0;
                1, 2, 3, 4: part = $urandom_range(0, full);
                7: part = 32'd0;
                8:
                begin
                    full = $urandom_range(1, 200);
                    part = $urandom_range(0, 300);
                end
                default: ;
            endcase
            send_frame(mode_t'($urandom_range(0, 3)), part, full);
        end

        // drain and let any stray word show up
        wait_strip_drained();
        repeat (LED_COUNT + 16) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("led_strip_progress_pattern_unit verification clean");
        else
            $display("led_strip_progress_pattern_unit verification failed");
        $finish;
    end
endmodule
